// ===== rtl/dmwtc_pkg.sv =====
package dmwtc_pkg;

    localparam int DATA_W          = 32;
    localparam int ADDR_W          = 16;
    localparam int WORD_ADDR_W     = ADDR_W - 2;
    localparam int LINE_OFFS_W     = 4;
    localparam int TAG_W           = ADDR_W - LINE_OFFS_W;
    localparam int IDX_BITS_W      = 4;
    localparam int PADDR_W         = 3;
    localparam int REG_SEL_W       = 1;

    localparam int MEM_WORDS_DEF      = 16384;
    localparam int MAX_INDEX_BITS_DEF = 8;

    localparam logic [REG_SEL_W-1:0] REG_CACHE_ENABLE = 1'b0;
    localparam logic [REG_SEL_W-1:0] REG_INDEX_BITS   = 1'b1;

    typedef logic [DATA_W-1:0] word_t;

endpackage

// ===== rtl/dmwtc_ram.sv =====
module dmwtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/direct_mapped_write_through_cache_unit.sv =====
// Path from input accept to result valid: a misaligned word goes straight to DONE; a hit
// or store passes MUL, MOD and ACC; a load with the cache off adds BYP, a load miss FILL.
// One word at a time: the next word is taken only after the result is registered, which
// waits for m_ready while a result is held; a miss streams its 4-word line through the single
// read port of the word memory. After reset a clearing pass zeroes the word memory,
// one word per cycle, with s_ready low; registers are still written.
module direct_mapped_write_through_cache_unit #(
    parameter int MEM_WORDS      = dmwtc_pkg::MEM_WORDS_DEF,
    parameter int MAX_INDEX_BITS = dmwtc_pkg::MAX_INDEX_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dmwtc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_func,
    input  logic [dmwtc_pkg::ADDR_W-1:0]    s_byte_address,
    input  dmwtc_pkg::word_t                s_store_value,

    output logic                            m_valid,
    input  logic                            m_ready,
    output dmwtc_pkg::word_t                m_load_value,
    output logic                            m_was_hit,
    output logic                            m_misaligned,
    output dmwtc_pkg::word_t                m_loads_seen,
    output dmwtc_pkg::word_t                m_load_hits_seen,
    output dmwtc_pkg::word_t                m_stores_seen,
    output dmwtc_pkg::word_t                m_store_hits_seen
);

    import dmwtc_pkg::*;

    localparam int MEM_AW     = $clog2(MEM_WORDS);
    localparam int LINE_W     = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
    localparam int LINE_COUNT = 1 << MAX_INDEX_BITS;
    localparam int LW_DEPTH   = LINE_COUNT * 4;
    localparam int LW_AW      = MAX_INDEX_BITS + 2;
    localparam int RECIP      = (1 << WORD_ADDR_W) / MEM_WORDS;
    localparam int PROD_W     = 2 * WORD_ADDR_W + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_FILL  = 3'd5;
    localparam logic [2:0] ST_BYP   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]              state_reg, state_next;
    logic [MEM_AW-1:0]       clr_cnt_reg;

    logic                    enable_reg;
    logic [IDX_BITS_W-1:0]   index_bits_reg;
    logic [LINE_COUNT-1:0]   valid_reg;

    logic                    func_reg;
    logic [ADDR_W-1:0]       addr_reg;
    word_t                   wdata_reg;
    logic [LINE_W-1:0]       line_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic [1:0]              offs_reg;
    logic [PROD_W-1:0]       prod1_reg;
    logic [WORD_ADDR_W-1:0]  prod2_reg;
    logic [MEM_AW-1:0]       base_slot_reg;
    logic [MEM_AW-1:0]       word_slot_reg;
    logic [MEM_AW-1:0]       fill_slot_reg;
    logic [2:0]              fill_k_reg;
    logic                    match_reg;
    word_t                   hitword_reg;

    word_t                   res_value_reg;
    logic                    res_hit_reg;
    logic                    res_bad_reg;

    word_t                   loads_reg, load_hits_reg, stores_reg, store_hits_reg;

    logic                    m_valid_reg;
    word_t                   m_load_value_reg;
    logic                    m_was_hit_reg, m_misaligned_reg;
    word_t                   m_loads_reg, m_load_hits_reg, m_stores_reg, m_store_hits_reg;

    logic                    cfg_wr;
    logic [REG_SEL_W-1:0]    reg_sel;
    logic [IDX_BITS_W-1:0]   active_bits;
    logic [TAG_W-1:0]        s_block, s_masked;
    logic [31:0]             s_line32;
    logic [WORD_ADDR_W-1:0]  s_base, base_reg14, rem;
    logic [PROD_W-1:0]       prod1_next;
    logic [31:0]             prod2_full, rem32, base32, word32, inc32;
    logic [MEM_AW-1:0]       inc_src;
    logic [MEM_AW-1:0]       inc_slot;
    logic [1:0]              wr_k;
    logic                    accept, out_load, match_next;

    logic                    mem_we, mem_re;
    logic [MEM_AW-1:0]       mem_waddr, mem_raddr;
    word_t                   mem_wdata, mem_rdata;
    logic                    lw_we, lw_re;
    logic [31:0]             lw_waddr32, lw_raddr32;
    word_t                   lw_wdata, lw_rdata;
    logic                    tag_we, tag_re;
    logic [TAG_W-1:0]        tag_rdata;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (reg_sel)
            REG_CACHE_ENABLE: prdata = {31'b0, enable_reg};
            REG_INDEX_BITS:   prdata = {{(32 - IDX_BITS_W){1'b0}}, index_bits_reg};
            default:          prdata = '0;
        endcase
    end

    assign active_bits = ({28'b0, index_bits_reg} > 32'(MAX_INDEX_BITS)) ?
                         IDX_BITS_W'(MAX_INDEX_BITS) : index_bits_reg;

    assign s_block    = s_byte_address[ADDR_W-1:LINE_OFFS_W];
    assign s_masked   = s_block & ~({TAG_W{1'b1}} << active_bits);
    assign s_line32   = 32'(s_masked) & 32'(LINE_COUNT - 1);
    assign s_base     = {s_block, 2'b00};
    assign prod1_next = PROD_W'(s_base) * PROD_W'(RECIP);

    assign prod2_full = 32'(prod1_reg[PROD_W-1:WORD_ADDR_W]) * 32'(MEM_WORDS);
    assign base_reg14 = {addr_reg[ADDR_W-1:LINE_OFFS_W], 2'b00};
    assign rem        = base_reg14 - prod2_reg;
    assign rem32      = 32'(rem);
    assign base32     = (rem32 >= 32'(MEM_WORDS)) ? rem32 - 32'(MEM_WORDS) : rem32;
    assign word32     = ((base32 + 32'(offs_reg)) >= 32'(MEM_WORDS)) ?
                        base32 + 32'(offs_reg) - 32'(MEM_WORDS) : base32 + 32'(offs_reg);

    assign inc_src  = (state_reg == ST_ACC) ? base_slot_reg : fill_slot_reg;
    assign inc32    = 32'(inc_src) + 32'd1;
    assign inc_slot = (inc32 >= 32'(MEM_WORDS)) ? '0 : inc32[MEM_AW-1:0];

    assign wr_k       = fill_k_reg[1:0] - 2'd1;
    assign match_next = enable_reg && valid_reg[line_reg] && (tag_rdata == tag_reg);

    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == MEM_AW'(MEM_WORDS - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_byte_address[1:0] != 2'b00) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_MOD;
            ST_MOD:  state_next = ST_ACC;
            ST_ACC: begin
                if (func_reg || match_reg) begin
                    state_next = ST_DONE;
                end else if (!enable_reg) begin
                    state_next = ST_BYP;
                end else begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: if (fill_k_reg == 3'd4) state_next = ST_DONE;
            ST_BYP:  state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = word_slot_reg;
        mem_wdata  = wdata_reg;
        mem_re     = 1'b0;
        mem_raddr  = word_slot_reg;
        lw_we      = 1'b0;
        lw_waddr32 = 32'(line_reg) * 32'd4 + 32'(offs_reg);
        lw_wdata   = wdata_reg;
        lw_re      = (state_reg == ST_MUL);
        lw_raddr32 = 32'(line_reg) * 32'd4 + 32'(offs_reg);
        tag_we     = 1'b0;
        tag_re     = (state_reg == ST_MUL);
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            ST_ACC: begin
                if (func_reg) begin
                    mem_we = 1'b1;
                    lw_we  = match_reg;
                end else if (!enable_reg) begin
                    mem_re = 1'b1;
                end else if (!match_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = base_slot_reg;
                end
            end
            ST_FILL: begin
                lw_we      = 1'b1;
                lw_waddr32 = 32'(line_reg) * 32'd4 + 32'(wr_k);
                lw_wdata   = mem_rdata;
                mem_re     = (fill_k_reg != 3'd4);
                mem_raddr  = fill_slot_reg;
                tag_we     = (fill_k_reg == 3'd4);
            end
            default: begin
            end
        endcase
    end

    dmwtc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_main_ram (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dmwtc_ram #(.WIDTH(DATA_W), .DEPTH(LW_DEPTH)) u_line_ram (
        .clk   (aclk),
        .we    (lw_we),
        .waddr (lw_waddr32[LW_AW-1:0]),
        .wdata (lw_wdata),
        .re    (lw_re),
        .raddr (lw_raddr32[LW_AW-1:0]),
        .rdata (lw_rdata)
    );

    dmwtc_ram #(.WIDTH(TAG_W), .DEPTH(LINE_COUNT)) u_tag_ram (
        .clk   (aclk),
        .we    (tag_we),
        .waddr (line_reg),
        .wdata (tag_reg),
        .re    (tag_re),
        .raddr (line_reg),
        .rdata (tag_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            enable_reg     <= 1'b0;
            index_bits_reg <= '0;
            valid_reg      <= '0;
            loads_reg      <= '0;
            load_hits_reg  <= '0;
            stores_reg     <= '0;
            store_hits_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end

            if (state_reg == ST_ACC) begin
                if (func_reg) begin
                    stores_reg <= stores_reg + 1'b1;
                    if (match_reg) begin
                        store_hits_reg <= store_hits_reg + 1'b1;
                    end
                end else begin
                    loads_reg <= loads_reg + 1'b1;
                    if (match_reg) begin
                        load_hits_reg <= load_hits_reg + 1'b1;
                    end
                end
            end

            // any register write drops every line
            if (cfg_wr) begin
                valid_reg <= '0;
                unique case (reg_sel)
                    REG_CACHE_ENABLE: enable_reg     <= pwdata[0];
                    REG_INDEX_BITS:   index_bits_reg <= pwdata[IDX_BITS_W-1:0];
                    default: begin
                    end
                endcase
            end else if (state_reg == ST_FILL && fill_k_reg == 3'd4) begin
                valid_reg[line_reg] <= 1'b1;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg      <= s_func;
            addr_reg      <= s_byte_address;
            wdata_reg     <= s_store_value;
            line_reg      <= s_line32[LINE_W-1:0];
            tag_reg       <= s_block >> active_bits;
            offs_reg      <= s_byte_address[3:2];
            prod1_reg     <= prod1_next;
            res_value_reg <= '0;
            res_hit_reg   <= 1'b0;
            res_bad_reg   <= (s_byte_address[1:0] != 2'b00);
        end

        if (state_reg == ST_MUL) begin
            prod2_reg <= prod2_full[WORD_ADDR_W-1:0];
        end

        if (state_reg == ST_MOD) begin
            base_slot_reg <= base32[MEM_AW-1:0];
            word_slot_reg <= word32[MEM_AW-1:0];
            match_reg     <= match_next;
            hitword_reg   <= lw_rdata;
        end

        if (state_reg == ST_ACC) begin
            fill_slot_reg <= inc_slot;
            fill_k_reg    <= 3'd1;
            res_hit_reg   <= match_reg;
            if (!func_reg && match_reg) begin
                res_value_reg <= hitword_reg;
            end
        end

        if (state_reg == ST_FILL) begin
            if (fill_k_reg != 3'd4) begin
                fill_slot_reg <= inc_slot;
                fill_k_reg    <= fill_k_reg + 3'd1;
            end
            if (wr_k == offs_reg) begin
                res_value_reg <= mem_rdata;
            end
        end

        if (state_reg == ST_BYP) begin
            res_value_reg <= mem_rdata;
        end

        if (out_load) begin
            m_load_value_reg <= res_value_reg;
            m_was_hit_reg    <= res_hit_reg;
            m_misaligned_reg <= res_bad_reg;
            m_loads_reg      <= loads_reg;
            m_load_hits_reg  <= load_hits_reg;
            m_stores_reg     <= stores_reg;
            m_store_hits_reg <= store_hits_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_load_value      = m_load_value_reg;
    assign m_was_hit         = m_was_hit_reg;
    assign m_misaligned      = m_misaligned_reg;
    assign m_loads_seen      = m_loads_reg;
    assign m_load_hits_seen  = m_load_hits_reg;
    assign m_stores_seen     = m_stores_reg;
    assign m_store_hits_seen = m_store_hits_reg;

endmodule

// ===== rtl/dmwtc_checker.sv =====
module dmwtc_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input dmwtc_pkg::word_t m_load_value,
    input logic             m_was_hit,
    input logic             m_misaligned
);

    import dmwtc_pkg::*;

    a_bad_word_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_misaligned |-> m_load_value == '0 && !m_was_hit)
        else $error("misaligned word carries data or a hit");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in flight");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_load_value) && $stable(m_was_hit))
        else $error("stalled result changed");

endmodule

bind direct_mapped_write_through_cache_unit dmwtc_checker u_dmwtc_checker (.*);

// ===== test/direct_mapped_write_through_cache_unit_test.sv =====
module direct_mapped_write_through_cache_unit_test;
    import dmwtc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int LINES         = 1 << MAX_INDEX_BITS_DEF;
    localparam int WORDS_IN_LINE = 4;
    localparam int POOL_SIZE     = 6;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 210;
    localparam int DIRECTED_ROWS = 28;
    localparam int REPORT_MAX    = 10;
    localparam int TAIL_CYCLES   = 20;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_STORE = 1'b1;

    localparam int PHASE_ENABLE [PHASES] = '{1, 1, 0, 1, 1, 1, 0, 1};
    localparam int PHASE_BITS   [PHASES] = '{8, 0, 3, 2, 15, 4, 0, 1};
    localparam int SEND_GAP_PCT [4]      = '{0, 83, 0, 36};
    localparam int RECV_STALL_PCT [4]    = '{0, 0, 83, 36};

    typedef struct packed {
        word_t load_value;
        logic  was_hit;
        logic  misaligned;
        word_t loads_seen;
        word_t load_hits_seen;
        word_t stores_seen;
        word_t store_hits_seen;
    } cache_reply_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  func;
        logic [REG_SEL_W-1:0]  reg_sel;
        logic [ADDR_W-1:0]     byte_address;
        word_t                 value;
        logic                  typed;
        cache_reply_t          reply;
    } plan_row_t;

    localparam cache_reply_t NO_REPLY = '0;

    localparam plan_row_t DIRECTED_PLAN [DIRECTED_ROWS] = '{
        '{ROW_WORD, FUNC_LOAD, REG_CACHE_ENABLE, 16'h0000, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b0, 32'd1, 32'd0, 32'd0, 32'd0}},
        '{ROW_WORD, FUNC_STORE, REG_CACHE_ENABLE, 16'hFFFC, 32'hFFFF_FFFF, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b0, 32'd1, 32'd0, 32'd1, 32'd0}},
        '{ROW_WORD, FUNC_LOAD, REG_CACHE_ENABLE, 16'hFFFC, 32'h0000_0000, 1'b1,
          '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'd2, 32'd0, 32'd1, 32'd0}},
        '{ROW_WORD, FUNC_LOAD, REG_CACHE_ENABLE, 16'h0001, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b1, 32'd2, 32'd0, 32'd1, 32'd0}},
        '{ROW_WORD, FUNC_STORE, REG_CACHE_ENABLE, 16'h0002, 32'hA5A5_A5A5, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b1, 32'd2, 32'd0, 32'd1, 32'd0}},
        '{ROW_WORD, FUNC_STORE, REG_CACHE_ENABLE, 16'h0003, 32'h5A5A_5A5A, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b1, 32'd2, 32'd0, 32'd1, 32'd0}},
        '{ROW_WORD, FUNC_STORE, REG_CACHE_ENABLE, 16'h0018, 32'h1234_5678, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b0, 32'd2, 32'd0, 32'd2, 32'd0}},
        '{ROW_REG,  FUNC_LOAD,  REG_CACHE_ENABLE, 16'h0000, 32'd1,  1'b0, NO_REPLY},
        '{ROW_REG,  FUNC_LOAD,  REG_INDEX_BITS,   16'h0000, 32'd15, 1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'h0010, 32'h0000_0000, 1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'h0018, 32'h0000_0000, 1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_STORE, REG_CACHE_ENABLE, 16'h0014, 32'h0000_FFFF, 1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'h0014, 32'h0000_0000, 1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_STORE, REG_CACHE_ENABLE, 16'h1010, 32'hDEAD_BEEF, 1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'h1010, 32'h0000_0000, 1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'h0010, 32'h0000_0000, 1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'hFFFC, 32'h0000_0000, 1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'hFFF0, 32'h0000_0000, 1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'h0011, 32'h0000_0000, 1'b0, NO_REPLY},
        '{ROW_REG,  FUNC_LOAD,  REG_INDEX_BITS,   16'h0000, 32'd0,  1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'h0020, 32'h0000_0000, 1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'h0024, 32'h0000_0000, 1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'h0030, 32'h0000_0000, 1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'h0020, 32'h0000_0000, 1'b0, NO_REPLY},
        '{ROW_REG,  FUNC_LOAD,  REG_INDEX_BITS,   16'h0000, 32'd8,  1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'h0018, 32'h0000_0000, 1'b0, NO_REPLY},
        '{ROW_REG,  FUNC_LOAD,  REG_CACHE_ENABLE, 16'h0000, 32'd0,  1'b0, NO_REPLY},
        '{ROW_WORD, FUNC_LOAD,  REG_CACHE_ENABLE, 16'h1010, 32'h0000_0000, 1'b0, NO_REPLY}
    };

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   psel           = 1'b0;
    logic                   penable        = 1'b0;
    logic                   pwrite         = 1'b0;
    logic [PADDR_W-1:0]     paddr          = '0;
    logic [31:0]            pwdata         = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic                   s_func         = 1'b0;
    logic [ADDR_W-1:0]      s_byte_address = '0;
    word_t                  s_store_value  = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    word_t                  m_load_value;
    logic                   m_was_hit;
    logic                   m_misaligned;
    word_t                  m_loads_seen;
    word_t                  m_load_hits_seen;
    word_t                  m_stores_seen;
    word_t                  m_store_hits_seen;

    bit [DATA_W-1:0]        main_words [MEM_WORDS_DEF];
    bit [DATA_W-1:0]        line_data  [LINES*WORDS_IN_LINE];
    bit [27:0]              line_tag   [LINES];
    bit                     line_ok    [LINES];
    bit [31:0]              n_loads;
    bit [31:0]              n_load_hits;
    bit [31:0]              n_stores;
    bit [31:0]              n_store_hits;
    bit                     cfg_enable;
    bit [IDX_BITS_W-1:0]    cfg_index_bits;

    cache_reply_t           pending_replies [$];
    cache_reply_t           seen_reply;
    cache_reply_t           want_reply;
    int                     mismatch_count = 0;
    int                     cycle_count    = 0;
    int                     send_gap_pct   = 0;
    int                     recv_stall_pct = 0;
    logic [11:0]            hot_blocks [POOL_SIZE];
    logic [11:0]            recent_block = '0;

    direct_mapped_write_through_cache_unit i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_byte_address    (s_byte_address),
        .s_store_value     (s_store_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_load_value      (m_load_value),
        .m_was_hit         (m_was_hit),
        .m_misaligned      (m_misaligned),
        .m_loads_seen      (m_loads_seen),
        .m_load_hits_seen  (m_load_hits_seen),
        .m_stores_seen     (m_stores_seen),
        .m_store_hits_seen (m_store_hits_seen)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic string reply_text(input cache_reply_t r);
        return $sformatf("load_value=%h was_hit=%b misaligned=%b loads=%0d load_hits=%0d stores=%0d store_hits=%0d",
                         r.load_value, r.was_hit, r.misaligned, r.loads_seen,
                         r.load_hits_seen, r.stores_seen, r.store_hits_seen);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_reply = '{m_load_value, m_was_hit, m_misaligned, m_loads_seen,
                           m_load_hits_seen, m_stores_seen, m_store_hits_seen};
            if (pending_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected word: %s", reply_text(seen_reply));
            end else begin
                want_reply = pending_replies.pop_front();
                if (seen_reply !== want_reply) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("mismatch expected: %s", reply_text(want_reply));
                        $display("         actual:   %s", reply_text(seen_reply));
                    end
                end
            end
        end
    end

    task automatic cache_lookup(input logic is_store, input logic [ADDR_W-1:0] addr,
                                input word_t wdata, output cache_reply_t reply);
        int          act;
        int          blk;
        int          offs;
        int          line;
        int          slot;
        bit [27:0]   tag;
        bit          match;
        reply = '0;
        reply.misaligned = (addr[1:0] != 2'b00);
        if (!reply.misaligned) begin
            blk   = int'(addr[15:4]);
            offs  = int'(addr[3:2]);
            act   = (cfg_index_bits > MAX_INDEX_BITS_DEF) ? MAX_INDEX_BITS_DEF
                                                          : int'(cfg_index_bits);
            line  = blk & ((1 << act) - 1) & (LINES - 1);
            tag   = 28'(blk >> act);
            slot  = line * WORDS_IN_LINE + offs;
            match = cfg_enable && line_ok[line] && (line_tag[line] == tag);
            if (is_store == FUNC_STORE) begin
                n_stores++;
                main_words[int'(addr[15:2]) % MEM_WORDS_DEF] = wdata;
                if (match) begin
                    n_store_hits++;
                    line_data[slot] = wdata;
                    reply.was_hit = 1'b1;
                end
            end else begin
                n_loads++;
                if (!cfg_enable) begin
                    reply.load_value = main_words[int'(addr[15:2]) % MEM_WORDS_DEF];
                end else if (match) begin
                    n_load_hits++;
                    reply.load_value = line_data[slot];
                    reply.was_hit = 1'b1;
                end else begin
                    for (int k = 0; k < WORDS_IN_LINE; k++)
                        line_data[line * WORDS_IN_LINE + k] =
                            main_words[(blk * WORDS_IN_LINE + k) % MEM_WORDS_DEF];
                    line_tag[line] = tag;
                    line_ok[line]  = 1'b1;
                    reply.load_value = line_data[slot];
                end
            end
        end
        reply.loads_seen      = n_loads;
        reply.load_hits_seen  = n_load_hits;
        reply.stores_seen     = n_stores;
        reply.store_hits_seen = n_store_hits;
    endtask

    task automatic send_word(input logic is_store, input logic [ADDR_W-1:0] addr,
                             input word_t wdata, input logic typed,
                             input cache_reply_t typed_reply);
        cache_reply_t predicted;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= is_store;
        s_byte_address <= addr;
        s_store_value  <= wdata;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cache_lookup(is_store, addr, wdata, predicted);
        pending_replies.push_back(typed ? typed_reply : predicted);
    endtask

    task automatic drain_words();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [REG_SEL_W-1:0] sel, input word_t value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_CACHE_ENABLE)
            cfg_enable = value[0];
        else
            cfg_index_bits = value[IDX_BITS_W-1:0];
        foreach (line_ok[i]) line_ok[i] = 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned roll;
        logic [1:0]  offs;
        roll = $urandom_range(0, 99);
        offs = 2'($urandom);
        if (roll < 6)
            return 16'($urandom);
        if (roll < 60)
            return {hot_blocks[$urandom_range(0, POOL_SIZE - 1)], offs, 2'b00};
        if (roll < 80)
            return {recent_block, offs, 2'b00};
        return {14'($urandom), 2'b00};
    endfunction

    initial begin
        int                 act;
        logic [ADDR_W-1:0]  addr;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_PLAN[i]) begin
            if (DIRECTED_PLAN[i].kind == ROW_REG) begin
                drain_words();
                write_reg(DIRECTED_PLAN[i].reg_sel, DIRECTED_PLAN[i].value);
            end else begin
                send_word(DIRECTED_PLAN[i].func, DIRECTED_PLAN[i].byte_address,
                          DIRECTED_PLAN[i].value, DIRECTED_PLAN[i].typed,
                          DIRECTED_PLAN[i].reply);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_words();
            write_reg(REG_CACHE_ENABLE, 32'(PHASE_ENABLE[p]));
            write_reg(REG_INDEX_BITS, 32'(PHASE_BITS[p]));
            send_gap_pct   = SEND_GAP_PCT[p % 4];
            recv_stall_pct = RECV_STALL_PCT[p % 4];
            act = (PHASE_BITS[p] > MAX_INDEX_BITS_DEF) ? MAX_INDEX_BITS_DEF : PHASE_BITS[p];
            // the last three hot blocks alias onto the first one's index to force evictions
            for (int k = 0; k < POOL_SIZE; k++)
                hot_blocks[k] = (k < 3) ? 12'($urandom)
                                        : 12'(hot_blocks[0] + ((k - 2) << act));
            repeat (PHASE_WORDS) begin
                addr = pick_address();
                recent_block = addr[15:4];
                send_word(1'($urandom), addr, $urandom, 1'b0, NO_REPLY);
            end
        end

        drain_words();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
